@@ rtl/core/ghbp_pkg.sv @@
// Shared types, constants and helper functions for the global-history
// branch predictor. No dependencies.
package ghbp_pkg;

    localparam int ADDR_W  = 32;
    localparam int CLASS_W = 3;
    localparam int COUNT_W = 32;
    localparam int CTR_W   = 2;
    localparam int NUM_CLASSES = 6;

    localparam logic [CLASS_W-1:0] CLASS_LIMIT = CLASS_W'(NUM_CLASSES);
    localparam logic [CTR_W-1:0]   CTR_MAX     = 2'd3;
    localparam logic [CTR_W-1:0]   CTR_MIN     = 2'd0;
    localparam logic [CTR_W-1:0]   CTR_TAKEN   = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef logic [CTR_W-1:0]   ctr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CLASS_W-1:0] class_t;

    // Statistics update request, one per retiring branch
    typedef struct packed {
        logic   en;
        class_t cls;
        logic   correct;
    } stat_upd_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    function automatic ctr_t ctr_update(input ctr_t c, input logic taken);
        ctr_t r;
        r = c;
        if (taken)
        begin
            if (c != CTR_MAX)
                r = c + ctr_t'(1);
        end
        else
        begin
            if (c != CTR_MIN)
                r = c - ctr_t'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ghbp_ctr_mem.sv @@
// Pattern table of 2-bit counters: single-port-write, registered-read RAM
// plus the post-reset clearing sweep. Depends on ghbp_pkg.
module ghbp_ctr_mem #(
    parameter int TABLE_W = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [TABLE_W-1:0]    rd_idx,
    output ghbp_pkg::ctr_t        rd_data,
    input  logic                  wr_en,
    input  logic [TABLE_W-1:0]    wr_idx,
    input  ghbp_pkg::ctr_t        wr_data,
    output logic                  clr_busy
);

    localparam int DEPTH = 1 << TABLE_W;

    ghbp_pkg::ctr_t       mem [DEPTH];
    ghbp_pkg::ctr_t       rd_data_reg;
    logic                 busy_reg;
    logic [TABLE_W-1:0]   clr_idx_reg;
    logic                 we;
    logic [TABLE_W-1:0]   widx;
    ghbp_pkg::ctr_t       wdata;

    always_comb
    begin
        we    = busy_reg | wr_en;
        widx  = busy_reg ? clr_idx_reg : wr_idx;
        wdata = busy_reg ? ghbp_pkg::CTR_MIN : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[widx] <= wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    // clear sweep, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_idx_reg == '1)
                busy_reg <= 1'b0;
            clr_idx_reg <= clr_idx_reg + TABLE_W'(1);
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = busy_reg;

endmodule

@@ rtl/core/ghbp_class_stats.sv @@
// Per-class total/correct counters, saturating; returns post-update counts,
// or zero for an out-of-range class. Depends on ghbp_pkg.
module ghbp_class_stats (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ghbp_pkg::stat_upd_t  upd,
    output ghbp_pkg::count_t     total_new,
    output ghbp_pkg::count_t     correct_new
);

    ghbp_pkg::count_t total_reg   [ghbp_pkg::NUM_CLASSES];
    ghbp_pkg::count_t correct_reg [ghbp_pkg::NUM_CLASSES];
    logic             in_range;
    ghbp_pkg::count_t tot_next;
    ghbp_pkg::count_t cor_next;

    always_comb
    begin
        in_range = upd.cls < ghbp_pkg::CLASS_LIMIT;
        tot_next = '0;
        cor_next = '0;
        if (in_range)
        begin
            tot_next = ghbp_pkg::sat_inc(total_reg[upd.cls]);
            cor_next = upd.correct ? ghbp_pkg::sat_inc(correct_reg[upd.cls])
                                   : correct_reg[upd.cls];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ghbp_pkg::NUM_CLASSES; i++)
            begin
                total_reg[i]   <= '0;
                correct_reg[i] <= '0;
            end
        end
        else if (upd.en && in_range)
        begin
            total_reg[upd.cls]   <= tot_next;
            correct_reg[upd.cls] <= cor_next;
        end
    end

    assign total_new   = tot_next;
    assign correct_new = cor_next;

endmodule

@@ rtl/core/global_history_branch_predictor_unit.sv @@
// Top level of the global-history (GAp) branch predictor.
// Depends on ghbp_pkg, ghbp_ctr_mem and ghbp_class_stats.
//
// Usage:
//   Branch channel (branch_valid/branch_ready) carries one resolved branch
//   per beat: branch_address, was_taken, branch_class. Result channel
//   (result_valid/result_ready) returns one beat per branch, in order:
//   predicted_taken, prediction_correct, class_total, class_correct.
//   Pipeline: an accepted branch reads the table into the read register as
//   it enters the compute stage, which updates table and counts into the output register.
//   Throughput: one branch per cycle while result_ready is high; the table
//   read-modify-write is covered by forwarding the last counter written.
//   Reset: history, class counts and control clear at once; the counter
//   table is then swept to zero, one entry per cycle, over all
//   2**(HISTORY_BITS+ADDRESS_INDEX_BITS) entries (4096 by default), while
//   branch_ready stays low.
//   Stall: with result_ready low the output register holds its beat and one
//   more branch can still be accepted into the compute stage; after that
//   branch_ready drops until the output drains.
module global_history_branch_predictor_unit #(
    parameter int HISTORY_BITS       = 8,
    parameter int ADDRESS_INDEX_BITS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         branch_valid,
    output logic                         branch_ready,
    input  logic [ghbp_pkg::ADDR_W-1:0]  branch_address,
    input  logic                         was_taken,
    input  ghbp_pkg::class_t             branch_class,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         predicted_taken,
    output logic                         prediction_correct,
    output ghbp_pkg::count_t             class_total,
    output ghbp_pkg::count_t             class_correct
);

    localparam int TABLE_W = HISTORY_BITS + ADDRESS_INDEX_BITS;
    localparam logic [ghbp_pkg::ADDR_W-1:0] ADDR_MASK =
        ghbp_pkg::ADDR_W'((64'd1 << ADDRESS_INDEX_BITS) - 64'd1);

    logic [HISTORY_BITS-1:0] hist_reg;
    logic [HISTORY_BITS-1:0] hist_next;
    logic [TABLE_W-1:0]      idx;
    logic                    accept;
    logic                    clr_busy;

    // compute stage
    logic                    s1_valid_reg;
    logic [TABLE_W-1:0]      s1_idx_reg;
    logic                    s1_taken_reg;
    ghbp_pkg::class_t        s1_cls_reg;
    logic                    s1_adv;

    // last counter written, for read-after-write forwarding
    logic                    lw_valid_reg;
    logic [TABLE_W-1:0]      lw_idx_reg;
    ghbp_pkg::ctr_t          lw_data_reg;

    ghbp_pkg::ctr_t          rd_data;
    ghbp_pkg::ctr_t          ctr_cur;
    ghbp_pkg::ctr_t          ctr_new;
    logic                    pred;
    logic                    correct;
    ghbp_pkg::stat_upd_t     upd;
    ghbp_pkg::count_t        total_new;
    ghbp_pkg::count_t        correct_new;

    // output register
    logic                    out_valid_reg;
    logic                    pred_reg;
    logic                    correct_reg;
    ghbp_pkg::count_t        total_reg;
    ghbp_pkg::count_t        corr_cnt_reg;

    always_comb
    begin
        hist_next = HISTORY_BITS'({hist_reg, was_taken});
        idx = TABLE_W'({hist_reg, {ghbp_pkg::ADDR_W{1'b0}}}
                       >> (ghbp_pkg::ADDR_W - ADDRESS_INDEX_BITS))
            | TABLE_W'(branch_address & ADDR_MASK);
        s1_adv       = s1_valid_reg && (!out_valid_reg || result_ready);
        branch_ready = !clr_busy && (!s1_valid_reg || s1_adv);
        accept       = branch_valid && branch_ready;
        ctr_cur      = (lw_valid_reg && lw_idx_reg == s1_idx_reg) ? lw_data_reg : rd_data;
        pred         = ctr_cur >= ghbp_pkg::CTR_TAKEN;
        correct      = pred == s1_taken_reg;
        ctr_new      = ghbp_pkg::ctr_update(ctr_cur, s1_taken_reg);
        upd.en       = s1_adv;
        upd.cls      = s1_cls_reg;
        upd.correct  = correct;
    end

    ghbp_ctr_mem #(
        .TABLE_W (TABLE_W)
    ) u_ctr_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_idx   (idx),
        .rd_data  (rd_data),
        .wr_en    (s1_adv),
        .wr_idx   (s1_idx_reg),
        .wr_data  (ctr_new),
        .clr_busy (clr_busy)
    );

    ghbp_class_stats u_class_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (upd),
        .total_new   (total_new),
        .correct_new (correct_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                hist_reg <= hist_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                lw_valid_reg <= 1'b1;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= idx;
            s1_taken_reg <= was_taken;
            s1_cls_reg   <= branch_class;
        end
        if (s1_adv)
        begin
            lw_idx_reg   <= s1_idx_reg;
            lw_data_reg  <= ctr_new;
            pred_reg     <= pred;
            correct_reg  <= correct;
            total_reg    <= total_new;
            corr_cnt_reg <= correct_new;
        end
    end

    assign result_valid       = out_valid_reg;
    assign predicted_taken    = pred_reg;
    assign prediction_correct = correct_reg;
    assign class_total        = total_reg;
    assign class_correct      = corr_cnt_reg;

    a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> hist_reg[0] == $past(was_taken))
        else $error("history did not take the branch outcome");

    a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s1_valid_reg && !out_valid_reg)
        else $error("branch in flight during table clear");

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result beat without a branch in compute stage");

    a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> corr_cnt_reg <= total_reg)
        else $error("correct count exceeds total count");

endmodule

@@ test/global_history_branch_predictor_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for global_history_branch_predictor_unit: a directed set of branches,
// then trained loop patterns mixed with random noise, each checked against a bench model.
// Depends on ghbp_pkg and the predictor RTL.
module global_history_branch_predictor_unit_test;

    localparam int HIST_BITS   = 8;
    localparam int INDEX_BITS  = 4;
    localparam int TABLE_BITS  = HIST_BITS + INDEX_BITS;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_POINT = 700;
    localparam int QUIET_FIRST = 300;
    localparam int QUIET_LAST  = 650;
    localparam int IDLE_PCT    = 6;

    typedef struct packed {
        logic [ghbp_pkg::ADDR_W-1:0] addr;
        logic                        taken;
        ghbp_pkg::class_t            cls;
        logic                        drain_first;
    } branch_t;

    typedef struct packed {
        logic             pred;
        logic             ok;
        ghbp_pkg::count_t total;
        ghbp_pkg::count_t hits;
    } outcome_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        branch_valid = 1'b0;
    logic                        branch_ready;
    logic [ghbp_pkg::ADDR_W-1:0] branch_address = '0;
    logic                        was_taken = 1'b0;
    ghbp_pkg::class_t            branch_class = '0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    logic                        predicted_taken;
    logic                        prediction_correct;
    ghbp_pkg::count_t            class_total;
    ghbp_pkg::count_t            class_correct;

    branch_t  pending_branches[$];
    outcome_t expected_outcomes[$];
    int       error_count = 0;
    int       sent_count = 0;
    logic     branch_fire = 1'b0;

    // Predictor state
    logic [HIST_BITS-1:0] history_model = '0;
    ghbp_pkg::ctr_t       counter_model [0:(1<<TABLE_BITS)-1];
    ghbp_pkg::count_t     total_model [0:ghbp_pkg::NUM_CLASSES-1];
    ghbp_pkg::count_t     hits_model [0:ghbp_pkg::NUM_CLASSES-1];

    global_history_branch_predictor_unit #(
        .HISTORY_BITS       (HIST_BITS),
        .ADDRESS_INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .branch_valid       (branch_valid),
        .branch_ready       (branch_ready),
        .branch_address     (branch_address),
        .was_taken          (was_taken),
        .branch_class       (branch_class),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .predicted_taken    (predicted_taken),
        .prediction_correct (prediction_correct),
        .class_total        (class_total),
        .class_correct      (class_correct)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic resolve_branch(input logic [ghbp_pkg::ADDR_W-1:0] addr, input logic taken,
                                  input ghbp_pkg::class_t cls);
        logic [TABLE_BITS-1:0] idx;
        ghbp_pkg::ctr_t        ctr;
        outcome_t              o;
        idx = {history_model, addr[INDEX_BITS-1:0]};
        ctr = counter_model[idx];
        o.pred = (ctr >= ghbp_pkg::CTR_TAKEN);
        o.ok = (o.pred == taken);
        o.total = '0;
        o.hits = '0;
        if (taken)
        begin
            if (ctr != ghbp_pkg::CTR_MAX)
                ctr = ctr + 2'd1;
        end
        else if (ctr != ghbp_pkg::CTR_MIN)
        begin
            ctr = ctr - 2'd1;
        end
        counter_model[idx] = ctr;
        history_model = {history_model[HIST_BITS-2:0], taken};
        // classes 6 and 7 predict and train but leave the statistics alone
        if (cls < ghbp_pkg::CLASS_LIMIT)
        begin
            if (total_model[cls] != ghbp_pkg::COUNT_MAX)
                total_model[cls] = total_model[cls] + 32'd1;
            if (o.ok && hits_model[cls] != ghbp_pkg::COUNT_MAX)
                hits_model[cls] = hits_model[cls] + 32'd1;
            o.total = total_model[cls];
            o.hits = hits_model[cls];
        end
        expected_outcomes.push_back(o);
    endtask

    task automatic queue_branch(input logic [ghbp_pkg::ADDR_W-1:0] addr, input logic taken,
                                input ghbp_pkg::class_t cls, input logic drain_first);
        branch_t b;
        b.addr = addr;
        b.taken = taken;
        b.cls = cls;
        b.drain_first = drain_first;
        pending_branches.push_back(b);
    endtask

    // Accepted beats on both channels, sampled at the rising edge
    always @(posedge clk)
    begin
        outcome_t o;
        branch_fire = rst_n && branch_valid && branch_ready;
        if (branch_fire)
        begin
            resolve_branch(branch_address, was_taken, branch_class);
            sent_count = sent_count + 1;
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result beat with nothing expected", $time);
                error_count = error_count + 1;
            end
            else
            begin
                o = expected_outcomes.pop_front();
                if (predicted_taken !== o.pred)
                begin
                    $display("%0t: predicted_taken expected %0b actual %0b",
                             $time, o.pred, predicted_taken);
                    error_count = error_count + 1;
                end
                if (prediction_correct !== o.ok)
                begin
                    $display("%0t: prediction_correct expected %0b actual %0b",
                             $time, o.ok, prediction_correct);
                    error_count = error_count + 1;
                end
                if (class_total !== o.total)
                begin
                    $display("%0t: class_total expected %h actual %h",
                             $time, o.total, class_total);
                    error_count = error_count + 1;
                end
                if (class_correct !== o.hits)
                begin
                    $display("%0t: class_correct expected %h actual %h",
                             $time, o.hits, class_correct);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Branch driver and result-side stalls, updated at the falling edge
    always @(negedge clk)
    begin
        int idle;
        idle = (sent_count >= QUIET_FIRST && sent_count < QUIET_LAST) ? 0 : IDLE_PCT;
        result_ready <= ($urandom_range(99) >= idle);
        if (rst_n && (!branch_valid || branch_fire))
        begin
            if (pending_branches.size() > 0
                && !(pending_branches[0].drain_first && expected_outcomes.size() > 0)
                && $urandom_range(99) >= idle)
            begin
                branch_address <= pending_branches[0].addr;
                was_taken <= pending_branches[0].taken;
                branch_class <= pending_branches[0].cls;
                branch_valid <= 1'b1;
                void'(pending_branches.pop_front());
            end
            else
            begin
                branch_valid <= 1'b0;
            end
        end
    end

    initial
    begin
        int                          n;
        int                          seg_len;
        int                          period;
        logic [ghbp_pkg::ADDR_W-1:0] base;
        ghbp_pkg::class_t            cls;

        for (int i = 0; i < (1 << TABLE_BITS); i++)
            counter_model[i] = ghbp_pkg::CTR_MIN;
        for (int c = 0; c < ghbp_pkg::NUM_CLASSES; c++)
        begin
            total_model[c] = '0;
            hits_model[c] = '0;
        end

        // Directed: address extremes, every class, counter saturation both ways
        queue_branch(32'h0000_0000, 1'b1, 3'd0, 1'b0);
        queue_branch(32'hFFFF_FFFF, 1'b0, 3'd5, 1'b0);
        for (int c = 0; c < 8; c++)
            queue_branch($urandom, c[0], ghbp_pkg::class_t'(c), 1'b0);
        for (int i = 0; i < 12; i++)
            queue_branch(32'h0000_0005, 1'b1, 3'd2, 1'b0);
        for (int i = 0; i < 3; i++)
            queue_branch(32'h0000_0005, 1'b0, 3'd7, 1'b0);

        // Random: mostly loop-like patterns that train the counters, some noise
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 70)
            begin
                base = $urandom;
                period = $urandom_range(6, 1);
                seg_len = $urandom_range(40, 10);
                cls = ghbp_pkg::class_t'($urandom_range(ghbp_pkg::NUM_CLASSES - 1));
                for (int i = 0; i < seg_len; i++)
                begin
                    // loop exit every (period+1)-th iteration
                    queue_branch(base, (i % (period + 1)) != period, cls,
                                 n == DRAIN_POINT);
                    n = n + 1;
                end
            end
            else
            begin
                seg_len = $urandom_range(20, 1);
                for (int i = 0; i < seg_len; i++)
                begin
                    queue_branch($urandom, 1'($urandom_range(1)),
                                 ghbp_pkg::class_t'($urandom_range(7)),
                                 n == DRAIN_POINT);
                    n = n + 1;
                end
            end
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_branches.size() == 0 && !branch_valid);
        wait (expected_outcomes.size() == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("[global_history_branch_predictor_unit] OK");
        else
            $display("[global_history_branch_predictor_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("%0t: timeout", $time);
        $display("[global_history_branch_predictor_unit] ERROR");
        $finish;
    end

endmodule
